// ----- hdl/rmts_pkg.sv -----
// Shared types and constants of the rate-monotonic tick scheduler.
package rmts_pkg;

    // Task slots in storage; the live task count must be at most this, and nothing checks it.
    localparam int SLOTS   = 4;
    localparam int IDX_W   = 2;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RUN_W   = 3;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 32;

    // Configuration register indexes of the first period and first work register.
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_BASE   = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REL,
        ST_SEL,
        ST_DL,
        ST_OUT
    } rmts_state_t;

    // Per-cycle datapath operation.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_REL,
        OP_SEL,
        OP_DL
    } rmts_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        rmts_op_t         op;
        logic [IDX_W-1:0] idx;
        logic             start;
        logic             out_load;
    } rmts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;
    } rmts_stat_t;

endpackage

// ----- hdl/rmts_ctrl.sv -----
// Sequencer that walks the task slots through release, selection and deadline phases.
module rmts_ctrl #(
    parameter int NUM_TASKS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rmts_pkg::rmts_stat_t stat,
    output rmts_pkg::rmts_cmd_t  cmd
);
    import rmts_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    rmts_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last;

    // State and slot counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign last = (idx_reg == LAST_IDX);

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        in_ready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.idx      = idx_reg;
        cmd.start    = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    idx_next   = '0;
                    state_next = ST_REL;
                end
            end
            ST_REL:
            begin
                cmd.op = OP_REL;
                if (last)
                begin
                    idx_next   = '0;
                    state_next = ST_SEL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SEL:
            begin
                cmd.op = OP_SEL;
                if (last)
                begin
                    idx_next   = '0;
                    state_next = ST_DL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DL:
            begin
                cmd.op = OP_DL;
                if (last)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                // Wait for the output register to free up.
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/rmts_dp.sv -----
// Task state, configuration registers and per-slot update logic of the scheduler.
module rmts_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmts_pkg::CFG_W-1:0]     cfg_data,
    input  logic [rmts_pkg::IDX_W-1:0]     query_task,
    input  rmts_pkg::rmts_cmd_t            cmd,
    output rmts_pkg::rmts_stat_t           stat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rmts_pkg::OUT_W-1:0]     out_data
);
    import rmts_pkg::*;

    logic [CFG_W-1:0] period_reg [SLOTS];
    logic [CFG_W-1:0] work_reg   [SLOTS];
    logic [CNT_W-1:0] cd_reg     [SLOTS];
    logic [CNT_W-1:0] left_reg   [SLOTS];
    logic [CNT_W-1:0] miss_reg   [SLOTS];

    logic [SLOTS-1:0] released_reg, missed_reg;
    logic             best_valid_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [CFG_W-1:0] best_per_reg;
    logic [IDX_W-1:0] query_reg;
    logic [CNT_W-1:0] qmiss_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic [IDX_W-1:0] i;
    logic [CFG_W-1:0] eff_per;
    logic [CNT_W-1:0] cd_cur, left_cur, miss_cur, miss_inc;
    logic [CNT_W-1:0] cd_next, left_next, miss_next;
    logic             missed_now, released_now, take_best;
    logic [CNT_W-1:0] dl_left;
    logic [RUN_W-1:0] running;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                period_reg[k] <= CFG_W'(1);
                work_reg[k]   <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index < CFG_WORK_BASE)
            begin
                period_reg[IDX_W'(cfg_index - CFG_PERIOD_BASE)] <= cfg_data;
            end
            else
            begin
                work_reg[IDX_W'(cfg_index - CFG_WORK_BASE)] <= cfg_data;
            end
        end
    end

    // Current slot's values.
    assign i        = cmd.idx;
    assign eff_per  = (period_reg[i] == '0) ? CFG_W'(1) : period_reg[i];
    assign cd_cur   = cd_reg[i];
    assign left_cur = left_reg[i];
    assign miss_cur = miss_reg[i];
    assign miss_inc = (miss_cur == '1) ? miss_cur : miss_cur + 1'b1;
    assign dl_left  = left_cur - CNT_W'(best_valid_reg && (best_idx_reg == i));
    assign take_best = (left_cur != '0) && (!best_valid_reg || (eff_per < best_per_reg));

    // Per-slot update for the current phase.
    always_comb
    begin
        cd_next      = cd_cur;
        left_next    = left_cur;
        miss_next    = miss_cur;
        missed_now   = 1'b0;
        released_now = 1'b0;
        unique case (cmd.op)
            OP_REL:
            begin
                if (cd_cur == '0)
                begin
                    released_now = 1'b1;
                    if (left_cur != '0)
                    begin
                        missed_now = 1'b1;
                        miss_next  = miss_inc;
                    end
                    left_next = work_reg[i];
                    cd_next   = eff_per;
                end
            end
            OP_DL:
            begin
                left_next = dl_left;
                if ((cd_cur == CNT_W'(1)) && (dl_left != '0))
                begin
                    missed_now = 1'b1;
                    miss_next  = miss_inc;
                    left_next  = '0;
                end
                if (cd_cur != '0)
                begin
                    cd_next = cd_cur - 1'b1;
                end
            end
            OP_SEL, OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Task state arrays.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                cd_reg[k]   <= '0;
                left_reg[k] <= '0;
                miss_reg[k] <= '0;
            end
        end
        else
        begin
            cd_reg[i]   <= cd_next;
            left_reg[i] <= left_next;
            miss_reg[i] <= miss_next;
        end
    end

    // Per-tick masks, selection winner and query capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            released_reg   <= '0;
            missed_reg     <= '0;
            best_valid_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_per_reg   <= '0;
            query_reg      <= '0;
            qmiss_reg      <= '0;
        end
        else if (cmd.start)
        begin
            released_reg   <= '0;
            missed_reg     <= '0;
            best_valid_reg <= 1'b0;
            query_reg      <= query_task;
            qmiss_reg      <= '0;
        end
        else
        begin
            if (released_now)
            begin
                released_reg[i] <= 1'b1;
            end
            if (missed_now)
            begin
                missed_reg[i] <= 1'b1;
            end
            if ((cmd.op == OP_SEL) && take_best)
            begin
                best_valid_reg <= 1'b1;
                best_idx_reg   <= i;
                best_per_reg   <= eff_per;
            end
            if ((cmd.op == OP_DL) && (i == query_reg))
            begin
                qmiss_reg <= miss_next;
            end
        end
    end

    assign running = best_valid_reg ? (RUN_W'(best_idx_reg) + 1'b1) : '0;

    // Output register; it holds a finished word until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {5'b0, qmiss_reg, missed_reg, released_reg, running};
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign stat.out_full = out_valid_reg && !out_ready;

endmodule

// ----- hdl/rate_monotonic_tick_scheduler_top.sv -----
// Top level of the rate-monotonic tick scheduler.
//
//   Channel   Direction  Contents
//   s_*       in         one tick word: query_task
//   m_*       out        one result word per tick
//   cfg_*     in         register writes: index 0..3 periods, 4..7 work counts
//
// In a tick the sequencer visits every task slot once in each of the release,
// selection and deadline phases. The next tick word is taken as soon as the
// sequencer is idle, while the previous result may still wait in the output
// register; a stalled result holds the sequencer in its final step. Reset
// clears all countdowns, work and miss counters, so every task releases on
// the first tick.
module rate_monotonic_tick_scheduler_top #(
    parameter int NUM_TASKS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: query_task[1:0], zero fill
    input  logic [rmts_pkg::IN_W-1:0]      s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: running_task[2:0], released_mask[6:3], missed_mask[10:7],
    // queried_misses[26:11], zero fill
    output logic [rmts_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_we,
    input  logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmts_pkg::CFG_W-1:0]     cfg_data
);
    import rmts_pkg::*;

    rmts_cmd_t  cmd;
    rmts_stat_t stat;

    // Sequencer.
    rmts_ctrl #(
        .NUM_TASKS (NUM_TASKS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Task state and result datapath.
    rmts_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .query_task (s_tdata[IDX_W-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule
